FILE: hdl/nnps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnps_pkg
// Shared types and constants for the nearest-neighbor plane scaler.
// ----------------------------------------------------------------------------
package nnps_pkg;

    // configuration register width and reset values
    localparam int CFG_W          = 11;
    localparam int DEF_MAX_DIM    = 1024;
    localparam int RST_SRC_WIDTH  = 800;
    localparam int RST_SRC_HEIGHT = 600;
    localparam int RST_DST_WIDTH  = 800;
    localparam int RST_DST_HEIGHT = 600;

    // apb address and data
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // register indexes
    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } t_reg_idx;

    // command modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    // command and result payloads
    typedef struct packed {
        logic       mode;
        logic [7:0] src_pixel;
    } t_cmd;

    typedef struct packed {
        logic [7:0] dst_pixel;
        logic       last_pixel;
    } t_result;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_MUL,
        S_LD_WR,
        S_FX_MUL,
        S_FX_DS,
        S_FX_DW,
        S_FY_MUL,
        S_FY_DS,
        S_FY_DW,
        S_FA_MUL,
        S_FA_RD,
        S_FOUT
    } t_state;

endpackage

FILE: hdl/nnps_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnps_div
// Restoring divider, one quotient bit per cycle, for the scaler index math.
// ----------------------------------------------------------------------------
module nnps_div
    import nnps_pkg::*;
#(
    parameter int NUM_W = 22,
    parameter int DEN_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0] r_num, n_num;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             ge;

    // one shift-subtract step
    always_comb begin
        rem_sh  = {r_rem, r_num[NUM_W-1]};
        ge      = (rem_sh >= {1'b0, r_den});
        rem_sub = rem_sh - {1'b0, r_den};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_num   = r_num;
        n_rem   = r_rem;
        n_den   = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_num  = i_dividend;
            n_rem  = '0;
            n_den  = i_divisor;
        end else if (r_busy) begin
            n_num = {r_num[NUM_W-2:0], ge};
            n_rem = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done     = r_done;
    assign o_quotient = r_num;

    // done is a single-cycle pulse
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held for more than one cycle");

    // no restart while a division runs
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    // partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt != '0) |-> (r_rem < r_den))
        else $error("divider remainder out of range");

endmodule

FILE: hdl/nearest_neighbor_plane_scaler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_plane_scaler_top
// Nearest-neighbor scaler for one 8-bit plane with an APB register port.
// ----------------------------------------------------------------------------
// load: busy through the size multiply and store write states
// fetch: busy through index multiplies, two bit-serial divider passes, a store
//   read and the output state; the result strobe is registered from that state
// one item at a time; results are presented for one cycle and cannot be stalled
// reset clears position counters, presets sizes; the plane store is not cleared
module nearest_neighbor_plane_scaler_top
    import nnps_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_cmd               i_cmd,
    output logic               o_result_valid,
    output t_result            o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int PROD_W      = 2 * DIM_W;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CMP_W       = (DIM_W > CFG_W) ? DIM_W : CFG_W;

    // registers
    logic [CFG_W-1:0]  r_src_width, r_src_height, r_dst_width, r_dst_height;
    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [ADDR_W-1:0] r_load_addr, n_load_addr;
    logic [IDX_W-1:0]  r_out_column, n_out_column;
    logic [IDX_W-1:0]  r_out_row, n_out_row;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [DIM_W-1:0]  r_xi, n_xi;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;
    logic [7:0]        r_rd_data;

    logic [7:0]        mem [STORE_DEPTH];

    logic [DIM_W-1:0]  sw, sh, dw, dh;
    logic [IDX_W-1:0]  col_used, row_used;
    logic [DIM_W-1:0]  col_inc, row_inc;
    logic [DIM_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [ADDR_W-1:0] ld_addr;
    logic [ADDR_W:0]   ld_inc;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] rd_addr;
    logic              div_start, div_done;
    logic [DIM_W-1:0]  div_den;
    logic [PROD_W-1:0] div_quo;
    logic              accept, cfg_wr;

    // clamp a register value to 1..MAX_DIM
    function automatic logic [DIM_W-1:0] f_dim(input logic [CFG_W-1:0] v);
        logic [CMP_W-1:0] w;
        w = CMP_W'(v);
        if (w == '0) begin
            return DIM_W'(1);
        end
        if (w > CMP_W'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(w);
    endfunction

    assign sw = f_dim(r_src_width);
    assign sh = f_dim(r_src_height);
    assign dw = f_dim(r_dst_width);
    assign dh = f_dim(r_dst_height);

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // apb register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_SRC_WIDTH:  prdata = PDATA_W'(r_src_width);
            REG_SRC_HEIGHT: prdata = PDATA_W'(r_src_height);
            REG_DST_WIDTH:  prdata = PDATA_W'(r_dst_width);
            REG_DST_HEIGHT: prdata = PDATA_W'(r_dst_height);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= CFG_W'(RST_SRC_WIDTH);
            r_src_height <= CFG_W'(RST_SRC_HEIGHT);
            r_dst_width  <= CFG_W'(RST_DST_WIDTH);
            r_dst_height <= CFG_W'(RST_DST_HEIGHT);
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_SRC_WIDTH:  r_src_width  <= pwdata[CFG_W-1:0];
                REG_SRC_HEIGHT: r_src_height <= pwdata[CFG_W-1:0];
                REG_DST_WIDTH:  r_dst_width  <= pwdata[CFG_W-1:0];
                REG_DST_HEIGHT: r_dst_height <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // stale positions fall back to zero
    assign col_used = (DIM_W'(r_out_column) < dw) ? r_out_column : '0;
    assign row_used = (DIM_W'(r_out_row) < dh) ? r_out_row : '0;
    assign col_inc  = DIM_W'(col_used) + DIM_W'(1);
    assign row_inc  = DIM_W'(row_used) + DIM_W'(1);

    // load address with wrap against the current plane size in r_prod
    assign ld_addr = (PROD_W'(r_load_addr) < r_prod) ? r_load_addr : '0;
    assign ld_inc  = {1'b0, ld_addr} + (ADDR_W + 1)'(1);
    assign rd_addr = r_prod[ADDR_W-1:0] + ADDR_W'(r_xi);

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_LD_MUL: begin
                mul_a = sw;
                mul_b = sh;
            end
            S_FX_MUL: begin
                mul_a = DIM_W'(col_used);
                mul_b = sw;
            end
            S_FY_MUL: begin
                mul_a = DIM_W'(row_used);
                mul_b = sh;
            end
            S_FA_MUL: begin
                mul_a = div_quo[DIM_W-1:0];
                mul_b = sw;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // full-width product of the shared multiplier
    assign mul_p = {{DIM_W{1'b0}}, mul_a} * {{DIM_W{1'b0}}, mul_b};

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_load_addr  = r_load_addr;
        n_out_column = r_out_column;
        n_out_row    = r_out_row;
        n_prod       = r_prod;
        n_xi         = r_xi;
        n_out_valid  = 1'b0;
        n_out        = r_out;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        div_start    = 1'b0;
        div_den      = dw;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd   = i_cmd;
                    n_state = (i_cmd.mode == MODE_FETCH) ? S_FX_MUL : S_LD_MUL;
                end
            end
            S_LD_MUL: begin
                n_prod  = mul_p;
                n_state = S_LD_WR;
            end
            S_LD_WR: begin
                mem_we      = 1'b1;
                n_load_addr = (PROD_W'(ld_inc) >= r_prod) ? '0 : ld_inc[ADDR_W-1:0];
                n_state     = S_IDLE;
            end
            S_FX_MUL: begin
                n_prod  = mul_p;
                n_state = S_FX_DS;
            end
            S_FX_DS: begin
                div_start = 1'b1;
                div_den   = dw;
                n_state   = S_FX_DW;
            end
            S_FX_DW: begin
                if (div_done) begin
                    n_xi    = div_quo[DIM_W-1:0];
                    n_state = S_FY_MUL;
                end
            end
            S_FY_MUL: begin
                n_prod  = mul_p;
                n_state = S_FY_DS;
            end
            S_FY_DS: begin
                div_start = 1'b1;
                div_den   = dh;
                n_state   = S_FY_DW;
            end
            S_FY_DW: begin
                if (div_done) begin
                    n_state = S_FA_MUL;
                end
            end
            S_FA_MUL: begin
                n_prod  = mul_p;
                n_state = S_FA_RD;
            end
            S_FA_RD: begin
                mem_re  = 1'b1;
                n_state = S_FOUT;
            end
            S_FOUT: begin
                n_out_valid    = 1'b1;
                n_out.dst_pixel  = r_rd_data;
                n_out.last_pixel = (col_inc == dw) && (row_inc == dh);
                // advance raster position with wrap
                if (col_inc >= dw) begin
                    n_out_column = '0;
                    n_out_row    = (row_inc >= dh) ? '0 : row_inc[IDX_W-1:0];
                end else begin
                    n_out_column = col_inc[IDX_W-1:0];
                    n_out_row    = row_used;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // shared divider
    nnps_div #(
        .NUM_W (PROD_W),
        .DEN_W (DIM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_load_addr  <= '0;
            r_out_column <= '0;
            r_out_row    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_load_addr  <= n_load_addr;
            r_out_column <= n_out_column;
            r_out_row    <= n_out_row;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_prod <= n_prod;
        r_xi   <= n_xi;
        r_out  <= n_out;
    end

    // plane store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[ld_addr] <= r_cmd.src_pixel;
        end
        if (mem_re) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    // each result transfer lasts one cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |=> !r_out_valid)
        else $error("result strobe held for more than one cycle");

    // a load never produces a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd.mode == MODE_LOAD) |-> ##2 !r_out_valid)
        else $error("load produced a result");

    // a result strobe only follows the output state
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $past(r_state == S_FOUT))
        else $error("result strobe without output state");

    // store read address stays inside the plane store
    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_re |-> (PROD_W'(rd_addr) < PROD_W'(STORE_DEPTH)))
        else $error("store read address out of range");

endmodule
